// ===== rtl/tls_pkg.sv =====
// Shared constants and types for the triangle level slicer.
package tls_pkg;

  localparam int NUM_CORNERS = 3;
  localparam int NUM_EDGES   = 3;
  localparam int KEY_HALF    = 32;
  localparam int WORD_BITS   = 32;

  typedef enum logic [1:0] {
    SEL_P,
    SEL_Q,
    SEL_INTERP
  } pt_sel_t;

endpackage

// ===== rtl/tls_lane.sv =====
// One edge lane: pipelined restoring divider, scaling multipliers and rounding.
module tls_lane #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] p_x,
  input  logic signed [CW-1:0] p_y,
  input  logic signed [CW-1:0] q_x,
  input  logic signed [CW-1:0] q_y,
  input  logic        [CW-1:0] un,
  input  logic        [CW-1:0] ud,
  input  tls_pkg::pt_sel_t     sel,
  output logic signed [31:0]   pt_x,
  output logic signed [31:0]   pt_y
);

  localparam int TF = 64 - CW;

  logic        [CW:0]   rem    [TF+1];
  logic        [CW-1:0] den    [TF+1];
  logic        [TF-1:0] quo    [TF+1];
  logic                 interp [TF+1];
  logic signed [CW-1:0] base_x [TF+1];
  logic signed [CW-1:0] base_y [TF+1];
  logic        [CW-1:0] mag_x  [TF+1];
  logic        [CW-1:0] mag_y  [TF+1];
  logic                 neg_x  [TF+1];
  logic                 neg_y  [TF+1];

  logic        [CW+1:0] rem2   [TF+1];
  logic                 ge     [TF+1];

  logic signed [CW:0]   dx;
  logic signed [CW:0]   dy;

  logic        [63:0]   prod_x;
  logic        [63:0]   prod_y;
  logic                 m_interp;
  logic signed [CW-1:0] m_base_x;
  logic signed [CW-1:0] m_base_y;
  logic                 m_neg_x;
  logic                 m_neg_y;

  logic        [CW-1:0] r_x;
  logic        [CW-1:0] r_y;
  logic signed [CW:0]   res_x;
  logic signed [CW:0]   res_y;

  assign dx = (CW+1)'(q_x) - (CW+1)'(p_x);
  assign dy = (CW+1)'(q_y) - (CW+1)'(p_y);

  always_comb begin
    rem2[0] = '0;
    ge[0]   = 1'b0;
    for (int k = 1; k <= TF; k++) begin
      rem2[k] = {rem[k-1], 1'b0};
      ge[k]   = rem2[k] >= (CW+2)'(den[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= (CW+1)'(un);
      den[0]    <= ud;
      quo[0]    <= '0;
      interp[0] <= (sel == tls_pkg::SEL_INTERP);
      base_x[0] <= (sel == tls_pkg::SEL_Q) ? q_x : p_x;
      base_y[0] <= (sel == tls_pkg::SEL_Q) ? q_y : p_y;
      mag_x[0]  <= CW'(dx[CW] ? -dx : dx);
      mag_y[0]  <= CW'(dy[CW] ? -dy : dy);
      neg_x[0]  <= dx[CW];
      neg_y[0]  <= dy[CW];
      for (int k = 1; k <= TF; k++) begin
        rem[k]    <= ge[k] ? (CW+1)'(rem2[k] - (CW+2)'(den[k-1])) : (CW+1)'(rem2[k]);
        den[k]    <= den[k-1];
        quo[k]    <= {quo[k-1][TF-2:0], ge[k]};
        interp[k] <= interp[k-1];
        base_x[k] <= base_x[k-1];
        base_y[k] <= base_y[k-1];
        mag_x[k]  <= mag_x[k-1];
        mag_y[k]  <= mag_y[k-1];
        neg_x[k]  <= neg_x[k-1];
        neg_y[k]  <= neg_y[k-1];
      end
      prod_x   <= 64'(mag_x[TF]) * 64'(quo[TF]);
      prod_y   <= 64'(mag_y[TF]) * 64'(quo[TF]);
      m_interp <= interp[TF];
      m_base_x <= base_x[TF];
      m_base_y <= base_y[TF];
      m_neg_x  <= neg_x[TF];
      m_neg_y  <= neg_y[TF];
    end
  end

  assign r_x = CW'((prod_x + (64'(1) << (TF - 1))) >> TF);
  assign r_y = CW'((prod_y + (64'(1) << (TF - 1))) >> TF);

  always_comb begin
    res_x = (CW+1)'(m_base_x);
    res_y = (CW+1)'(m_base_y);
    if (m_interp) begin
      res_x = m_neg_x ? res_x - $signed({1'b0, r_x}) : res_x + $signed({1'b0, r_x});
      res_y = m_neg_y ? res_y - $signed({1'b0, r_y}) : res_y + $signed({1'b0, r_y});
    end
  end

  assign pt_x = 32'(res_x);
  assign pt_y = 32'(res_y);

endmodule

// ===== rtl/triangle_level_slicer.sv =====
// Top level of the triangle level slicer: edge selection, edge lane pair, output register.
// A new triangle word is taken every cycle unless a finished segment word waits stalled at
// the output; a straddling triangle gives one segment word via the bit-per-stage dividers;
// other triangles give nothing. The user must write the level only while the block is idle;
// the block itself does not enforce it.
module triangle_level_slicer #(
  parameter int ID_BITS    = 32,
  parameter int COORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               level_we,
  input  logic        [31:0] level_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [31:0] a_id,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic        [31:0] b_id,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic        [31:0] c_id,
  input  logic signed [31:0] c_x,
  input  logic signed [31:0] c_y,
  input  logic signed [31:0] c_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [63:0] first_edge,
  output logic        [63:0] second_edge,
  output logic signed [31:0] first_px,
  output logic signed [31:0] first_py,
  output logic signed [31:0] second_px,
  output logic signed [31:0] second_py
);

  localparam int CW    = COORD_BITS;
  localparam int IW    = ID_BITS;
  localparam int TF    = 64 - CW;
  localparam int DEPTH = TF + 2;

  logic signed [CW-1:0] level;
  logic                 en;

  logic        [IW-1:0] cid [tls_pkg::NUM_CORNERS];
  logic signed [CW-1:0] cx  [tls_pkg::NUM_CORNERS];
  logic signed [CW-1:0] cy  [tls_pkg::NUM_CORNERS];
  logic signed [CW-1:0] cz  [tls_pkg::NUM_CORNERS];

  logic                 crossed [tls_pkg::NUM_EDGES];
  logic signed [CW-1:0] e_px    [tls_pkg::NUM_EDGES];
  logic signed [CW-1:0] e_py    [tls_pkg::NUM_EDGES];
  logic signed [CW-1:0] e_qx    [tls_pkg::NUM_EDGES];
  logic signed [CW-1:0] e_qy    [tls_pkg::NUM_EDGES];
  logic        [CW-1:0] e_un    [tls_pkg::NUM_EDGES];
  logic        [CW-1:0] e_ud    [tls_pkg::NUM_EDGES];
  tls_pkg::pt_sel_t     e_sel   [tls_pkg::NUM_EDGES];
  logic        [63:0]   e_key   [tls_pkg::NUM_EDGES];

  logic [1:0] l0;
  logic [1:0] l1;
  logic       straddle;

  logic                 s0_valid;
  logic signed [CW-1:0] s0_px  [2];
  logic signed [CW-1:0] s0_py  [2];
  logic signed [CW-1:0] s0_qx  [2];
  logic signed [CW-1:0] s0_qy  [2];
  logic        [CW-1:0] s0_un  [2];
  logic        [CW-1:0] s0_ud  [2];
  tls_pkg::pt_sel_t     s0_sel [2];
  logic        [63:0]   s0_key [2];

  logic        lv    [DEPTH];
  logic [63:0] lkey0 [DEPTH];
  logic [63:0] lkey1 [DEPTH];

  logic signed [31:0] lane_x [2];
  logic signed [31:0] lane_y [2];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign cid[0] = IW'(a_id);
  assign cid[1] = IW'(b_id);
  assign cid[2] = IW'(c_id);
  assign cx[0]  = $signed(CW'($unsigned(a_x)));
  assign cy[0]  = $signed(CW'($unsigned(a_y)));
  assign cz[0]  = $signed(CW'($unsigned(a_z)));
  assign cx[1]  = $signed(CW'($unsigned(b_x)));
  assign cy[1]  = $signed(CW'($unsigned(b_y)));
  assign cz[1]  = $signed(CW'($unsigned(b_z)));
  assign cx[2]  = $signed(CW'($unsigned(c_x)));
  assign cy[2]  = $signed(CW'($unsigned(c_y)));
  assign cz[2]  = $signed(CW'($unsigned(c_z)));

  always_comb begin
    logic [1:0]         u;
    logic [1:0]         v;
    logic [1:0]         pi;
    logic [1:0]         qi;
    logic signed [CW:0] dn;
    logic signed [CW:0] dd;
    u  = '0;
    v  = '0;
    pi = '0;
    qi = '0;
    dn = '0;
    dd = '0;
    for (int e = 0; e < tls_pkg::NUM_EDGES; e++) begin
      u = 2'(e);
      v = (e == tls_pkg::NUM_EDGES - 1) ? 2'd0 : 2'(e + 1);
      crossed[e] = (cz[u] >= level) != (cz[v] >= level);
      if (cid[u] < cid[v]) begin
        pi = u;
        qi = v;
      end else begin
        pi = v;
        qi = u;
      end
      e_px[e]  = cx[pi];
      e_py[e]  = cy[pi];
      e_qx[e]  = cx[qi];
      e_qy[e]  = cy[qi];
      e_key[e] = {tls_pkg::KEY_HALF'(cid[pi]), tls_pkg::KEY_HALF'(cid[qi])};
      dn = (CW+1)'(level) - (CW+1)'(cz[pi]);
      dd = (CW+1)'(cz[qi]) - (CW+1)'(cz[pi]);
      e_un[e] = CW'(dn[CW] ? -dn : dn);
      e_ud[e] = CW'(dd[CW] ? -dd : dd);
      if (cz[pi] == level) begin
        e_sel[e] = tls_pkg::SEL_P;
      end else if (cz[qi] == level) begin
        e_sel[e] = tls_pkg::SEL_Q;
      end else if (e_ud[e] == '0 || e_un[e] >= e_ud[e]) begin
        e_sel[e] = tls_pkg::SEL_P;
      end else begin
        e_sel[e] = tls_pkg::SEL_INTERP;
      end
    end
  end

  assign straddle = crossed[0] || crossed[1] || crossed[2];
  assign l0       = crossed[0] ? 2'd0 : 2'd1;
  assign l1       = (crossed[0] && crossed[1]) ? 2'd1 : 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (level_we) begin
      level <= $signed(CW'(level_data));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid && straddle;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_px[0]  <= e_px[l0];
      s0_py[0]  <= e_py[l0];
      s0_qx[0]  <= e_qx[l0];
      s0_qy[0]  <= e_qy[l0];
      s0_un[0]  <= e_un[l0];
      s0_ud[0]  <= e_ud[l0];
      s0_sel[0] <= e_sel[l0];
      s0_key[0] <= e_key[l0];
      s0_px[1]  <= e_px[l1];
      s0_py[1]  <= e_py[l1];
      s0_qx[1]  <= e_qx[l1];
      s0_qy[1]  <= e_qy[l1];
      s0_un[1]  <= e_un[l1];
      s0_ud[1]  <= e_ud[l1];
      s0_sel[1] <= e_sel[l1];
      s0_key[1] <= e_key[l1];
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    tls_lane #(
      .CW (CW)
    ) u_lane (
      .clk  (clk),
      .en   (en),
      .p_x  (s0_px[g]),
      .p_y  (s0_py[g]),
      .q_x  (s0_qx[g]),
      .q_y  (s0_qy[g]),
      .un   (s0_un[g]),
      .ud   (s0_ud[g]),
      .sel  (s0_sel[g]),
      .pt_x (lane_x[g]),
      .pt_y (lane_y[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        lv[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      lv[0] <= s0_valid;
      for (int k = 1; k < DEPTH; k++) begin
        lv[k] <= lv[k-1];
      end
      out_valid <= lv[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lkey0[0] <= s0_key[0];
      lkey1[0] <= s0_key[1];
      for (int k = 1; k < DEPTH; k++) begin
        lkey0[k] <= lkey0[k-1];
        lkey1[k] <= lkey1[k-1];
      end
      first_edge  <= lkey0[DEPTH-1];
      second_edge <= lkey1[DEPTH-1];
      first_px    <= lane_x[0];
      first_py    <= lane_y[0];
      second_px   <= lane_x[1];
      second_py   <= lane_y[1];
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("Input stalled with no word waiting at the output.");

  a_tail_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (en && lv[DEPTH-1]) |=> out_valid)
    else $error("A finished segment did not reach the output register.");

  a_pipeline_frozen: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(s0_valid) && $stable(lv[DEPTH-1])))
    else $error("Pipeline moved while the output was stalled.");

  a_accept_straddle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && straddle) |=> s0_valid)
    else $error("A straddling triangle was dropped at the first stage.");

endmodule

// ===== dv/triangle_level_slicer_tb.sv =====
// Self-checking testbench for the triangle level slicer: directed and random triangles.
module triangle_level_slicer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] id;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } corner_t;

  typedef struct {
    logic [63:0] e0;
    logic [63:0] e1;
    logic [31:0] p0x;
    logic [31:0] p0y;
    logic [31:0] p1x;
    logic [31:0] p1y;
  } segment_t;

  logic clk = 0;
  logic rst = 1;
  logic level_we = 0;
  logic [31:0] level_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] a_id = '0, b_id = '0, c_id = '0;
  logic signed [31:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [31:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [31:0] c_x = '0, c_y = '0, c_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [63:0] first_edge, second_edge;
  logic signed [31:0] first_px, first_py, second_px, second_py;

  segment_t expected_segments[$];
  logic signed [31:0] level_q = 0;
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 0;
  int stall_left = 0;

  triangle_level_slicer i_dut (
    .clk(clk), .rst(rst), .level_we(level_we), .level_data(level_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_id(a_id), .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_id(b_id), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_id(c_id), .c_x(c_x), .c_y(c_y), .c_z(c_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .first_edge(first_edge), .second_edge(second_edge),
    .first_px(first_px), .first_py(first_py),
    .second_px(second_px), .second_py(second_py)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("triangle_level_slicer_tb: errors");
      $finish;
    end
  end

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [31:0] lerp(longint p, longint q, logic [63:0] t);
    longint d;
    logic [127:0] r;
    d = q - p;
    r = ({64'd0, abs64(d)} * {64'd0, t} + (128'd1 << 31)) >> 32;
    return 32'((d < 0) ? p - longint'(r[63:0]) : p + longint'(r[63:0]));
  endfunction

  function automatic void crossing(corner_t p, corner_t q, output logic [31:0] ox,
                                   output logic [31:0] oy);
    logic [63:0] un, ud, t;
    if (p.z == level_q) begin
      ox = p.x; oy = p.y;
    end else if (q.z == level_q) begin
      ox = q.x; oy = q.y;
    end else begin
      un = abs64(longint'(level_q) - longint'(p.z));
      ud = abs64(longint'(q.z) - longint'(p.z));
      if (ud == 0 || un >= ud) begin
        ox = p.x; oy = p.y;
      end else begin
        t = (un << 32) / ud;
        ox = lerp(p.x, q.x, t);
        oy = lerp(p.y, q.y, t);
      end
    end
  endfunction

  function automatic void slice_triangle(corner_t corners[3]);
    segment_t s;
    logic [63:0] keys[2];
    logic [31:0] px[2], py[2];
    corner_t u, v;
    int n;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      u = corners[i];
      v = corners[(i + 1) % 3];
      if (n < 2 && ((u.z >= level_q) != (v.z >= level_q))) begin
        keys[n] = (u.id < v.id) ? {u.id, v.id} : {v.id, u.id};
        if (u.id < v.id) crossing(u, v, px[n], py[n]);
        else crossing(v, u, px[n], py[n]);
        n++;
      end
    end
    if (n == 2) begin
      s.e0 = keys[0]; s.e1 = keys[1];
      s.p0x = px[0]; s.p0y = py[0]; s.p1x = px[1]; s.p1y = py[1];
      expected_segments = {expected_segments, s};
    end
  endfunction

  task automatic send_triangle(corner_t corners[3], int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    {a_id, a_x, a_y, a_z} <= corners[0];
    {b_id, b_x, b_y, b_z} <= corners[1];
    {c_id, c_x, c_y, c_z} <= corners[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    slice_triangle(corners);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_level(logic [31:0] value);
    drain();
    level_we <= 1;
    level_data <= value;
    @(posedge clk);
    level_we <= 0;
    level_q = value;
  endtask

  function automatic logic [31:0] rand_z();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return level_q;
      2: return level_q + $urandom_range(0, 3) - 1;
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return level_q + $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return $signed($urandom_range(0, 32'hfffff)) - 32'sh7ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void random_triangle(output corner_t corners[3]);
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 5))
        0: corners[i].id = $urandom;
        1: corners[i].id = base;
        default: corners[i].id = base + $urandom_range(0, 7);
      endcase
      corners[i].x = rand_coord();
      corners[i].y = rand_coord();
      corners[i].z = rand_z();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_segments.size() == 0) begin
        $display("%0t unexpected word: edges %h %h", $time, first_edge, second_edge);
        errors++;
      end else begin
        segment_t e;
        e = expected_segments.pop_front();
        if (e.e0 !== first_edge)
          $display("%0t first_edge exp %h got %h", $time, e.e0, first_edge);
        if (e.e1 !== second_edge)
          $display("%0t second_edge exp %h got %h", $time, e.e1, second_edge);
        if (e.p0x !== first_px)
          $display("%0t first_px exp %h got %h", $time, e.p0x, first_px);
        if (e.p0y !== first_py)
          $display("%0t first_py exp %h got %h", $time, e.p0y, first_py);
        if (e.p1x !== second_px)
          $display("%0t second_px exp %h got %h", $time, e.p1x, second_px);
        if (e.p1y !== second_py)
          $display("%0t second_py exp %h got %h", $time, e.p1y, second_py);
        if (e.e0 !== first_edge || e.e1 !== second_edge || e.p0x !== first_px ||
            e.p0y !== first_py || e.p1x !== second_px || e.p1y !== second_py)
          errors++;
      end
    end
  end

  bit random_stall = 0;
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1;
    end else if (!random_stall) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else if (out_valid && !out_stall) begin
      stall_left = $urandom_range(0, 6);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end else begin
      out_stall <= 0;
    end
  end

  initial begin
    hold_off = 0;
  end

  task automatic test_directed();
    corner_t corners[3];
    logic [31:0] zs[8][3];
    zs = '{'{0, 0, 0}, '{-1, 0, 1}, '{32'h7fffffff, 32'h80000000, 0},
           '{5, -5, 5}, '{-3, 0, -3}, '{0, -1, -1}, '{32'h80000000, 32'h80000000, 1},
           '{-7, 9, 100}};
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 3; i++) begin
        corners[i].id = (k == 3) ? 32'hffffffff : (k == 4 ? 0 : 3 - i + k);
        corners[i].x = (i == 0) ? 32'h7fffffff : (i == 1 ? 32'h80000000 : 32'h00010000);
        corners[i].y = (i == 1) ? 32'h7fffffff : (i == 2 ? 32'h80000000 : -32'sh8000);
        corners[i].z = zs[k][i];
      end
      send_triangle(corners, 0);
    end
  endtask

  task automatic test_random(int count, bit gaps);
    corner_t corners[3];
    random_stall = gaps;
    for (int n = 0; n < count; n++) begin
      random_triangle(corners);
      send_triangle(corners, gaps ? $urandom_range(0, 6) : 0);
    end
    random_stall = 0;
  endtask

  task automatic test_backpressure();
    corner_t corners[3];
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int n = 0; n < 120; n++) begin
        random_triangle(corners);
        corners[0].z = level_q - 10;
        corners[1].z = level_q + 10;
        send_triangle(corners, 0);
      end
    join
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    drain();
    write_level(32'h80000000);
    test_directed();
    write_level(32'h7fffffff);
    test_directed();
    write_level(32'h00018000);
    test_random(300, 1);
    write_level($urandom);
    test_random(300, 1);
    write_level(32'hfffe0000);
    test_backpressure();
    test_random(300, 0);
    drain();
    if (errors == 0) begin
      $display("triangle_level_slicer_tb: clean");
    end else begin
      $display("triangle_level_slicer_tb: errors");
    end
    $finish;
  end
endmodule
